### rtl/tlpw_pkg.sv
// ----------------------------------------------------------------------------
// tlpw_pkg
// Shared types, sizes and helper functions for the two-level page walker.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpw_pkg;

	localparam int FRAMES            = 256;
	localparam int ENTRIES_PER_TABLE = 8;
	localparam int VIRTUAL_PAGES     = 64;
	localparam int PROCESSES         = 16;

	localparam int FRAME_W = $clog2(FRAMES);
	localparam int NFF_W   = $clog2(FRAMES + 1);
	localparam int IDX_W   = $clog2(ENTRIES_PER_TABLE);
	localparam int PID_W   = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;

	localparam int PID_FIELD_W  = 4;
	localparam int PAGE_FIELD_W = 6;
	localparam int S_TDATA_W    = ((PID_FIELD_W + PAGE_FIELD_W + 7) / 8) * 8;
	localparam int M_TDATA_W    = 64;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_REF = 1'b1;

	typedef struct packed {
		logic               valid;
		logic [FRAME_W-1:0] frame;
		logic [7:0]         refs;
	} entry_t;

	typedef entry_t [ENTRIES_PER_TABLE-1:0] row_t;

	typedef struct packed {
		logic [FRAME_W-1:0] base;
		logic [8:0]         frames;
		logic [8:0]         faults;
		logic [15:0]        references;
	} proc_t;

	typedef struct packed {
		logic             cmd;
		logic [PID_W-1:0] pid;
		logic [IDX_W-1:0] idx1;
		logic [IDX_W-1:0] idx2;
	} item_t;

	typedef struct packed {
		logic [15:0] references;
		logic [8:0]  faults;
		logic [8:0]  frames;
		logic [7:0]  page_refs;
		logic [7:0]  table_refs;
		logic        l2_fault;
		logic        l1_fault;
		logic [7:0]  frame;
		logic        status;
	} res_t;

	typedef struct packed {
		logic               we;
		logic [FRAME_W-1:0] waddr;
		row_t               wdata;
		logic [FRAME_W-1:0] raddr;
	} tbl_req_t;

	typedef struct packed {
		logic             we;
		logic [PID_W-1:0] waddr;
		proc_t            wdata;
		logic [PID_W-1:0] raddr;
	} proc_req_t;

	typedef struct packed {
		logic             oom;
		logic [NFF_W-1:0] nff;
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROC,
		ST_L1,
		ST_L2,
		ST_OUT
	} state_t;

	// Largest q with q * m <= v; the compares are independent of each other.
	function automatic logic [5:0] quot6(input logic [5:0] v, input int m);
		logic [5:0] q;
		q = '0;
		for (int i = 1; i < 64; i++) begin
			if (int'(v) >= i * m) begin
				q = 6'(i);
			end
		end
		return q;
	endfunction

	function automatic logic [8:0] sat_inc9(input logic [8:0] v);
		return (v == 9'h1FF) ? v : v + 9'd1;
	endfunction

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

`default_nettype wire

### rtl/tlpw_ram.sv
// ----------------------------------------------------------------------------
// tlpw_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/tlpw_walk.sv
// ----------------------------------------------------------------------------
// tlpw_walk
// Walk sequencer: reads the process record, then the level-one and level-two
// table rows, allocates frames on demand and writes the changed rows back.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpw_walk
	import tlpw_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire item_t item,
	output logic       in_ready,
	input  wire logic  out_free,
	output logic       push,
	output res_t       res,
	input  wire row_t  tbl_rdata,
	output tbl_req_t   tbl_req,
	input  wire proc_t proc_rdata,
	output proc_req_t  proc_req,
	output stat_t      stat
);

	state_t                 state_q, state_nxt;
	item_t                  item_q;
	logic [NFF_W-1:0]       nff_q, nff_nxt;
	logic                   oom_q, oom_nxt;
	logic [PROCESSES-1:0]   pvalid_q;
	logic                   pset;
	proc_t                  proc_q, proc_nxt, proc_cur, pnew;
	res_t                   res_q, res_nxt;
	logic                   fresh_q, fresh_nxt;
	logic [FRAME_W-1:0]     l2_frame_q, l2_frame_nxt;
	logic                   alloc_ok;
	logic [FRAME_W-1:0]     nff_frame;
	row_t                   row1, row1n, row2, row2n;
	entry_t                 e1, e1n, e2, e2n;

	assign proc_cur  = pvalid_q[item_q.pid] ? proc_rdata : '0;
	assign alloc_ok  = (nff_q != NFF_W'(FRAMES));
	assign nff_frame = nff_q[FRAME_W-1:0];
	assign row1      = tbl_rdata;
	assign e1        = row1[item_q.idx1];
	assign row2      = fresh_q ? '0 : tbl_rdata;
	assign e2        = row2[item_q.idx2];
	assign res       = res_q;
	assign stat      = '{oom: oom_q, nff: nff_q};

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_PROC;
				end
			end
			ST_PROC: begin
				if (oom_q || item_q.cmd == CMD_ADD) begin
					state_nxt = ST_OUT;
				end else begin
					state_nxt = ST_L1;
				end
			end
			ST_L1: begin
				if (!e1.valid && !alloc_ok) begin
					state_nxt = ST_OUT;
				end else begin
					state_nxt = ST_L2;
				end
			end
			ST_L2: begin
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_nxt = in_valid ? ST_PROC : ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		push           = 1'b0;
		tbl_req        = '0;
		proc_req       = '0;
		proc_req.raddr = item.pid;
		nff_nxt        = nff_q;
		oom_nxt        = oom_q;
		proc_nxt       = proc_q;
		res_nxt        = res_q;
		fresh_nxt      = fresh_q;
		l2_frame_nxt   = l2_frame_q;
		pset           = 1'b0;
		e1n            = e1;
		row1n          = row1;
		e2n            = e2;
		row2n          = row2;
		pnew           = proc_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_PROC: begin
				res_nxt            = '0;
				res_nxt.frames     = proc_cur.frames;
				res_nxt.faults     = proc_cur.faults;
				res_nxt.references = proc_cur.references;
				proc_nxt           = proc_cur;
				if (oom_q) begin
					res_nxt.status = 1'b1;
				end else if (item_q.cmd == CMD_ADD) begin
					if (!alloc_ok) begin
						oom_nxt        = 1'b1;
						res_nxt.status = 1'b1;
					end else begin
						tbl_req.we          = 1'b1;
						tbl_req.waddr       = nff_frame;
						tbl_req.wdata       = '0;
						pnew                = '0;
						pnew.base           = nff_frame;
						pnew.frames         = sat_inc9(proc_cur.frames);
						proc_req.we         = 1'b1;
						proc_req.waddr      = item_q.pid;
						proc_req.wdata      = pnew;
						pset                = 1'b1;
						nff_nxt             = nff_q + NFF_W'(1);
						res_nxt.frame       = 8'(nff_frame);
						res_nxt.frames      = pnew.frames;
						res_nxt.faults      = '0;
						res_nxt.references  = '0;
					end
				end else begin
					tbl_req.raddr = proc_cur.base;
				end
			end
			ST_L1: begin
				if (!e1.valid && !alloc_ok) begin
					oom_nxt        = 1'b1;
					res_nxt.status = 1'b1;
				end else begin
					if (!e1.valid) begin
						e1n.valid       = 1'b1;
						e1n.frame       = nff_frame;
						nff_nxt         = nff_q + NFF_W'(1);
						proc_nxt.frames = sat_inc9(proc_q.frames);
						proc_nxt.faults = sat_inc9(proc_q.faults);
						res_nxt.l1_fault = 1'b1;
					end
					e1n.refs             = e1.refs + 8'd1;
					row1n[item_q.idx1]   = e1n;
					tbl_req.we           = 1'b1;
					tbl_req.waddr        = proc_q.base;
					tbl_req.wdata        = row1n;
					tbl_req.raddr        = e1n.frame;
					fresh_nxt            = !e1.valid;
					l2_frame_nxt         = e1n.frame;
					res_nxt.table_refs   = e1n.refs;
					res_nxt.frames       = proc_nxt.frames;
					res_nxt.faults       = proc_nxt.faults;
				end
			end
			ST_L2: begin
				if (!e2.valid && !alloc_ok) begin
					oom_nxt        = 1'b1;
					res_nxt.status = 1'b1;
				end else begin
					if (!e2.valid) begin
						e2n.valid        = 1'b1;
						e2n.frame        = nff_frame;
						nff_nxt          = nff_q + NFF_W'(1);
						pnew.frames      = sat_inc9(proc_q.frames);
						pnew.faults      = sat_inc9(proc_q.faults);
						res_nxt.l2_fault = 1'b1;
					end
					e2n.refs           = e2.refs + 8'd1;
					row2n[item_q.idx2] = e2n;
					pnew.references    = sat_inc16(proc_q.references);
					res_nxt.frame      = 8'(e2n.frame);
					res_nxt.page_refs  = e2n.refs;
				end
				// A freshly taken table is written back even on failure so it reads as empty.
				tbl_req.we          = 1'b1;
				tbl_req.waddr       = l2_frame_q;
				tbl_req.wdata       = row2n;
				proc_req.we         = 1'b1;
				proc_req.waddr      = item_q.pid;
				proc_req.wdata      = pnew;
				pset                = 1'b1;
				proc_nxt            = pnew;
				res_nxt.frames      = pnew.frames;
				res_nxt.faults      = pnew.faults;
				res_nxt.references  = pnew.references;
			end
			ST_OUT: begin
				push     = out_free;
				in_ready = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			nff_q    <= '0;
			oom_q    <= 1'b0;
			pvalid_q <= '0;
		end else begin
			state_q <= state_nxt;
			nff_q   <= nff_nxt;
			oom_q   <= oom_nxt;
			if (pset) begin
				pvalid_q[item_q.pid] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= item;
		end
		proc_q     <= proc_nxt;
		res_q      <= res_nxt;
		fresh_q    <= fresh_nxt;
		l2_frame_q <= l2_frame_nxt;
	end

endmodule

`default_nettype wire

### rtl/two_level_page_walk_demand_alloc_core.sv
// ----------------------------------------------------------------------------
// two_level_page_walk_demand_alloc_core
// Two-level page table walker with demand frame allocation.
// ----------------------------------------------------------------------------
// Each transaction on the slave side is either an add (tuser low), which gives
// the process a fresh first-level table frame, or a reference (tuser high),
// which walks both table levels, taking frames from a bump allocator when an
// entry is invalid. All page table rows live in one memory with one row per
// frame, and process records in a second memory. A reference runs through the
// process, level-one and level-two states before its result is pushed into the
// output register; an add, and every transaction once the out-of-memory status
// is set, goes from the process state straight to the output, and a reference
// that runs out of frames at the first level skips the level-two state. The
// walk is bound by the registered read of the table memory, which is read and
// written back once per level. Frames are never reused, and a table row reads
// as empty once its frame is taken, so no clearing pass is needed after reset.
// Once the allocator runs dry, the out-of-memory status sticks until reset.
`default_nettype none

module two_level_page_walk_demand_alloc_core
	import tlpw_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// process_id [3:0], page [9:4], zero fill above
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// command [0]
	input  wire logic                 s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// frame_number [7:0], level1_fault [8], level2_fault [9],
	// table_entry_refs [17:10], page_entry_refs [25:18], process_frames [34:26],
	// process_faults [43:35], process_references [59:44], zero fill above
	output logic      [M_TDATA_W-1:0] m_tdata,
	// status [0]
	output logic                      m_tuser
);

	item_t      item;
	logic [5:0] pid6, page6, vpage, q1;
	logic       out_free;
	logic       push;
	res_t       res;
	row_t       tbl_rdata;
	tbl_req_t   tbl_req;
	proc_t      proc_rdata;
	proc_req_t  proc_req;
	stat_t      stat;
	logic       m_valid_q;
	res_t       m_data_q;

	assign pid6      = 6'(s_tdata[PID_FIELD_W-1:0]);
	assign page6     = s_tdata[PID_FIELD_W+PAGE_FIELD_W-1:PID_FIELD_W];
	assign vpage     = page6 - 6'(quot6(page6, VIRTUAL_PAGES) * VIRTUAL_PAGES);
	assign q1        = quot6(vpage, ENTRIES_PER_TABLE);
	assign item.cmd  = s_tuser;
	assign item.pid  = PID_W'(pid6 - 6'(quot6(pid6, PROCESSES) * PROCESSES));
	assign item.idx1 = IDX_W'(q1 - 6'(quot6(q1, ENTRIES_PER_TABLE) * ENTRIES_PER_TABLE));
	assign item.idx2 = IDX_W'(vpage - 6'(q1 * ENTRIES_PER_TABLE));

	assign out_free = !m_valid_q || m_tready;

	tlpw_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.item       (item),
		.in_ready   (s_tready),
		.out_free   (out_free),
		.push       (push),
		.res        (res),
		.tbl_rdata  (tbl_rdata),
		.tbl_req    (tbl_req),
		.proc_rdata (proc_rdata),
		.proc_req   (proc_req),
		.stat       (stat)
	);

	tlpw_ram #(
		.WIDTH ($bits(row_t)),
		.DEPTH (FRAMES)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_req.we),
		.waddr (tbl_req.waddr),
		.wdata (tbl_req.wdata),
		.raddr (tbl_req.raddr),
		.rdata (tbl_rdata)
	);

	tlpw_ram #(
		.WIDTH ($bits(proc_t)),
		.DEPTH (PROCESSES)
	) u_proc_ram (
		.clk   (clk),
		.we    (proc_req.we),
		.waddr (proc_req.waddr),
		.wdata (proc_req.wdata),
		.raddr (proc_req.raddr),
		.rdata (proc_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (push) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			m_data_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_TDATA_W'(m_data_q[$bits(res_t)-1:1]);
	assign m_tuser  = m_data_q.status;

`ifndef SYNTHESIS
	a_nff_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.nff <= NFF_W'(FRAMES))
		else $error("Frame allocator ran past the last frame.");

	a_oom_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stat.oom |=> stat.oom)
		else $error("Out-of-memory flag cleared without reset.");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!m_valid_q || m_tready))
		else $error("Result pushed into an occupied output register.");

	a_walk_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !push)
		else $error("Result pushed in the cycle after a transaction was accepted.");
`endif

endmodule

`default_nettype wire

### sim/page_walk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_walk_checker
// Watches both stream sides of the page walker, keeps its own copy of the
// page tables, the frame allocator and the per-process counters, and
// compares every result transaction with the oldest predicted walk.
// ----------------------------------------------------------------------------

module page_walk_checker
	import tlpw_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	// process_id [3:0], page [9:4], zero fill above
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// command [0]
	input  wire logic                 s_tuser,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	// frame_number [7:0], level1_fault [8], level2_fault [9],
	// table_entry_refs [17:10], page_entry_refs [25:18], process_frames [34:26],
	// process_faults [43:35], process_references [59:44], zero fill above
	input  wire logic [M_TDATA_W-1:0] m_tdata,
	// status [0]
	input  wire logic                 m_tuser,
	output int                        errors,
	output int                        outstanding
);

	localparam int SLOTS = FRAMES * ENTRIES_PER_TABLE;

	typedef struct packed {
		logic        status;
		logic [7:0]  frame;
		logic        l1_fault;
		logic        l2_fault;
		logic [7:0]  table_refs;
		logic [7:0]  page_refs;
		logic [8:0]  frames;
		logic [8:0]  faults;
		logic [15:0] references;
	} walk_result_t;

	int         frame_cursor;
	bit         out_of_frames;
	bit [7:0]   root_frame [PROCESSES];
	bit         pte_valid [SLOTS];
	bit [7:0]   pte_frame [SLOTS];
	bit [7:0]   pte_refs [SLOTS];
	bit [8:0]   proc_frames [PROCESSES];
	bit [8:0]   proc_faults [PROCESSES];
	bit [15:0]  proc_refs [PROCESSES];

	walk_result_t expected_walks [$];
	walk_result_t want;

	function automatic void clear_walker_state();
		frame_cursor = 0;
		out_of_frames = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			pte_valid[i] = 1'b0;
			pte_frame[i] = '0;
			pte_refs[i] = '0;
		end
		for (int p = 0; p < PROCESSES; p++) begin
			root_frame[p] = '0;
			proc_frames[p] = '0;
			proc_faults[p] = '0;
			proc_refs[p] = '0;
		end
	endfunction

	function automatic int entry_slot(input int frame, input int idx);
		return (frame * ENTRIES_PER_TABLE + idx) % SLOTS;
	endfunction

	// Returns the frame taken from the bump allocator, or -1 when none is left.
	function automatic int take_frame(input int pid);
		int fr;
		if (frame_cursor >= FRAMES) begin
			return -1;
		end
		fr = frame_cursor;
		frame_cursor++;
		if (proc_frames[pid] != 9'h1FF) begin
			proc_frames[pid]++;
		end
		return fr;
	endfunction

	function automatic void wipe_table(input int frame);
		int s;
		for (int i = 0; i < ENTRIES_PER_TABLE; i++) begin
			s = entry_slot(frame, i);
			pte_valid[s] = 1'b0;
			pte_refs[s] = '0;
		end
	endfunction

	function automatic walk_result_t walk_page_tables(input logic cmd,
			input logic [PID_FIELD_W-1:0] pid_field, input logic [PAGE_FIELD_W-1:0] page_field);
		walk_result_t r;
		int pid;
		int page;
		int s1;
		int s2;
		int fr;
		bit ok;
		r = '0;
		pid = int'(pid_field) % PROCESSES;
		page = int'(page_field) % VIRTUAL_PAGES;
		ok = 1'b1;
		if (out_of_frames) begin
			r.status = 1'b1;
		end else if (cmd == CMD_ADD) begin
			fr = take_frame(pid);
			if (fr < 0) begin
				out_of_frames = 1'b1;
				r.status = 1'b1;
			end else begin
				root_frame[pid] = 8'(fr);
				wipe_table(fr);
				proc_faults[pid] = '0;
				proc_refs[pid] = '0;
				r.frame = 8'(fr);
			end
		end else begin
			s1 = entry_slot(root_frame[pid], (page / ENTRIES_PER_TABLE) % ENTRIES_PER_TABLE);
			if (!pte_valid[s1]) begin
				fr = take_frame(pid);
				if (fr < 0) begin
					out_of_frames = 1'b1;
					r.status = 1'b1;
					ok = 1'b0;
				end else begin
					if (proc_faults[pid] != 9'h1FF) begin
						proc_faults[pid]++;
					end
					pte_frame[s1] = 8'(fr);
					pte_valid[s1] = 1'b1;
					wipe_table(fr);
					r.l1_fault = 1'b1;
				end
			end
			if (ok) begin
				pte_refs[s1] = pte_refs[s1] + 8'd1;
				r.table_refs = pte_refs[s1];
				s2 = entry_slot(pte_frame[s1], page % ENTRIES_PER_TABLE);
				if (!pte_valid[s2]) begin
					fr = take_frame(pid);
					if (fr < 0) begin
						out_of_frames = 1'b1;
						r.status = 1'b1;
						ok = 1'b0;
					end else begin
						if (proc_faults[pid] != 9'h1FF) begin
							proc_faults[pid]++;
						end
						pte_frame[s2] = 8'(fr);
						pte_valid[s2] = 1'b1;
						r.l2_fault = 1'b1;
					end
				end
				if (ok) begin
					pte_refs[s2] = pte_refs[s2] + 8'd1;
					r.page_refs = pte_refs[s2];
					r.frame = pte_frame[s2];
					if (proc_refs[pid] != 16'hFFFF) begin
						proc_refs[pid]++;
					end
				end
			end
		end
		r.frames = proc_frames[pid];
		r.faults = proc_faults[pid];
		r.references = proc_refs[pid];
		return r;
	endfunction

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_walker_state();
			expected_walks.delete();
			errors = 0;
			outstanding <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_walks.push_back(walk_page_tables(s_tuser,
					s_tdata[PID_FIELD_W-1:0],
					s_tdata[PID_FIELD_W+PAGE_FIELD_W-1:PID_FIELD_W]));
			end
			if (m_tvalid && m_tready) begin
				if (expected_walks.size() == 0) begin
					$error("result transaction arrived with no walk expected");
					errors++;
				end else begin
					want = expected_walks.pop_front();
					check_field("status", want.status, m_tuser);
					check_field("frame_number", want.frame, m_tdata[7:0]);
					check_field("level1_fault", want.l1_fault, m_tdata[8]);
					check_field("level2_fault", want.l2_fault, m_tdata[9]);
					check_field("table_entry_refs", want.table_refs, m_tdata[17:10]);
					check_field("page_entry_refs", want.page_refs, m_tdata[25:18]);
					check_field("process_frames", want.frames, m_tdata[34:26]);
					check_field("process_faults", want.faults, m_tdata[43:35]);
					check_field("process_references", want.references, m_tdata[59:44]);
				end
			end
			outstanding <= expected_walks.size();
		end
	end

endmodule

### sim/two_level_page_walk_demand_alloc_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_walk_demand_alloc_core_test
// Drives add and reference transactions into the page walker: a directed
// opening, then a long stretch that hammers a hot page to wrap the entry
// counts, then broad random traffic that runs the frame allocator dry.
// Both sides idle at random. The checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------

module two_level_page_walk_demand_alloc_core_test;
	import tlpw_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RANDOM_ITEMS = 900;
	localparam int WARM_ITEMS   = 650;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;

	int checker_errors;
	int checker_outstanding;
	int cycle_count = 0;
	int rx_stall = 0;
	int rx_pick;

	bit                     added [PROCESSES];
	logic [PID_FIELD_W-1:0] hot_pid;
	logic [PAGE_FIELD_W-1:0] hot_page;
	logic [PAGE_FIELD_W-1:0] warm_pages [6];

	always #(CLK_PERIOD / 2) clk = ~clk;

	two_level_page_walk_demand_alloc_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	page_walk_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.errors      (checker_errors),
		.outstanding (checker_outstanding)
	);

	// The receiver stalls at random, but starts no new stall one stretch in four.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (rx_stall != 0) begin
			rx_stall <= rx_stall - 1;
			m_tready <= 1'b0;
		end else if (((cycle_count >> 8) % 4) == 2) begin
			m_tready <= 1'b1;
		end else begin
			rx_pick = $urandom_range(0, 15);
			if (rx_pick < 10) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				rx_stall <= (rx_pick < 15) ? $urandom_range(0, 2) : $urandom_range(10, 40);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("two_level_page_walk_demand_alloc_core_test: errors");
		$finish;
	end

	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 15);
		if (r < 8) begin
			return 0;
		end
		if (r < 14) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(input logic cmd, input logic [PID_FIELD_W-1:0] pid,
			input logic [PAGE_FIELD_W-1:0] page, input bit quiet);
		int gap;
		gap = pick_gap(quiet);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {{(S_TDATA_W - PID_FIELD_W - PAGE_FIELD_W){1'b0}}, page, pid};
		if (cmd == CMD_ADD) begin
			added[pid] = 1'b1;
		end
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [PID_FIELD_W-1:0] pick_added_pid();
		logic [PID_FIELD_W-1:0] p;
		p = PID_FIELD_W'($urandom_range(0, PROCESSES - 1));
		while (!added[p]) begin
			p = PID_FIELD_W'($urandom_range(0, PROCESSES - 1));
		end
		return p;
	endfunction

	initial begin
		int r;
		bit quiet;
		logic [PID_FIELD_W-1:0] pid;
		logic [PAGE_FIELD_W-1:0] page;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(CMD_ADD, 4'd0, 6'd63, 1'b0);
		send_item(CMD_REF, 4'd0, 6'd0, 1'b0);
		send_item(CMD_REF, 4'd0, 6'd0, 1'b1);
		send_item(CMD_REF, 4'd0, 6'd7, 1'b1);
		send_item(CMD_REF, 4'd0, 6'd8, 1'b0);
		send_item(CMD_REF, 4'd0, 6'd63, 1'b0);
		send_item(CMD_ADD, 4'd15, 6'd0, 1'b1);
		send_item(CMD_REF, 4'd15, 6'd63, 1'b1);
		send_item(CMD_REF, 4'd15, 6'd56, 1'b0);
		send_item(CMD_REF, 4'd15, 6'd42, 1'b0);
		send_item(CMD_REF, 4'd15, 6'd21, 1'b1);
		send_item(CMD_ADD, 4'd10, 6'd42, 1'b1);
		send_item(CMD_ADD, 4'd5, 6'd21, 1'b0);
		send_item(CMD_REF, 4'd10, 6'd0, 1'b0);
		send_item(CMD_REF, 4'd5, 6'd63, 1'b1);
		// Re-adding a process gives a fresh table and clears faults and references.
		send_item(CMD_ADD, 4'd15, 6'd63, 1'b0);
		send_item(CMD_REF, 4'd15, 6'd63, 1'b1);
		send_item(CMD_REF, 4'd15, 6'd63, 1'b1);
		send_item(CMD_REF, 4'd0, 6'd0, 1'b0);
		send_item(CMD_REF, 4'd0, 6'd7, 1'b1);

		hot_pid = pick_added_pid();
		hot_page = PAGE_FIELD_W'($urandom_range(0, VIRTUAL_PAGES - 1));
		foreach (warm_pages[k]) begin
			warm_pages[k] = PAGE_FIELD_W'($urandom_range(0, VIRTUAL_PAGES - 1));
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = ((i / 64) % 4) == 1;
			page = PAGE_FIELD_W'($urandom_range(0, VIRTUAL_PAGES - 1));
			if (i < WARM_ITEMS) begin
				r = $urandom_range(0, 63);
				if (r == 0) begin
					pid = PID_FIELD_W'($urandom_range(0, PROCESSES - 1));
					if (pid == hot_pid) begin
						pid = pid + 1'b1;
					end
					send_item(CMD_ADD, pid, page, quiet);
				end else if (r < 34) begin
					send_item(CMD_REF, hot_pid, hot_page, quiet);
				end else if (r < 42) begin
					send_item(CMD_REF, hot_pid, {hot_page[5:3], page[2:0]}, quiet);
				end else begin
					send_item(CMD_REF, pick_added_pid(), warm_pages[$urandom_range(0, 5)],
						quiet);
				end
			end else begin
				r = $urandom_range(0, 15);
				if (r < 2) begin
					send_item(CMD_ADD, PID_FIELD_W'($urandom_range(0, PROCESSES - 1)), page,
						quiet);
				end else begin
					send_item(CMD_REF, pick_added_pid(), page, quiet);
				end
			end
		end
		s_tvalid <= 1'b0;
		@(posedge clk);

		while (checker_outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (checker_errors == 0 && checker_outstanding == 0) begin
			$display("two_level_page_walk_demand_alloc_core_test: clean");
		end else begin
			$display("two_level_page_walk_demand_alloc_core_test: errors");
		end
		$finish;
	end

endmodule
